/* hw/rtl/moi_pkg.sv */
package moi_pkg;

  // Store depth and timestamp width
  localparam int MAX_INTERVALS = 256;
  localparam int TIME_BITS     = 48;

  // Field and word widths
  localparam int TS_FIELD_W = 48;
  localparam int S_TDATA_W  = ((TS_FIELD_W + 7) / 8) * 8;
  localparam int IVL_W      = TIME_BITS + 1;
  localparam int MED_W      = TIME_BITS + 2;
  localparam int M_TDATA_W  = ((MED_W + 7) / 8) * 8;
  localparam int CNT_W      = $clog2(MAX_INTERVALS + 1);
  localparam int HALF_W     = CNT_W - 1;

  typedef logic signed [IVL_W-1:0] ivl_t;
  typedef logic signed [MED_W-1:0] med_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // place a new interval in order
    logic shift;  // move every entry one cell toward the head
    logic clr;    // drop all entries
  } ctl_t;

endpackage

/* hw/rtl/median_of_intervals_top.sv */
// Median of the intervals between successive timestamps of a run.
// Input channel s_*: one word per timestamp; s_tlast marks the final
// timestamp of a run. From the second word of a run on, the difference to
// the previous timestamp is placed in order in a chain of 256 cells, one
// word per cycle. Intervals beyond 256 are dropped and flagged.
// Output channel m_*: one word per run, after the word with s_tlast.
// Its tdata holds twice the median interval (one fractional bit), tuser
// flags an empty run and dropped intervals.
// Throughput: one timestamp per cycle within a run. After the last word the
// chain is drained toward its head until the middle entries pass (this is
// skipped when no interval is stored), then the result is formed in the emit
// step; s_tready is low during that time. m_tvalid is registered and rises
// once the emit step has loaded the result into the output register.
// The result sits in an output register, so the next run streams in while
// it waits; a second result waits in the final step until that register is
// taken by m_tready.
// Reset (rst, synchronous) empties the chain and clears the run state and
// the output valid flag.
module median_of_intervals_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [moi_pkg::S_TDATA_W-1:0]   s_tdata,   // [47:0] timestamp
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [moi_pkg::M_TDATA_W-1:0]   m_tdata,   // [49:0] median_x2, rest zero
  output logic [1:0]                      m_tuser    // [0] empty_res, [1] overflow
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  localparam int CNT_W  = moi_pkg::CNT_W;
  localparam int HALF_W = moi_pkg::HALF_W;
  localparam int MED_W  = moi_pkg::MED_W;
  localparam int TB     = moi_pkg::TIME_BITS;

  logic [1:0]              state;
  logic [TB-1:0]           prev_time;
  logic                    have_prev;
  logic [CNT_W-1:0]        count;
  logic                    dropped;
  logic [HALF_W-1:0]       step;
  moi_pkg::ivl_t           mid_lo;
  moi_pkg::ivl_t           mid_hi;
  logic [moi_pkg::MED_W-1:0] out_med;
  logic                    out_empty;
  logic                    out_ovf;

  logic [TB-1:0]           ts;
  moi_pkg::ivl_t           ivl;
  moi_pkg::ivl_t           head_val;
  moi_pkg::ctl_t           ctl;
  logic                    s_acc;
  logic                    full;
  logic [HALF_W-1:0]       half;
  logic                    out_free;
  moi_pkg::med_t           med_sum;

  assign s_tready = (state == ST_RUN);
  assign s_acc    = s_tvalid && s_tready;
  assign ts       = s_tdata[TB-1:0];
  assign ivl      = $signed({1'b0, ts}) - $signed({1'b0, prev_time});
  assign full     = (count == CNT_W'(moi_pkg::MAX_INTERVALS));
  assign half     = count[CNT_W-1:1];
  assign out_free = !m_tvalid || m_tready;

  // Sum of the middle entries, or the middle entry doubled for an odd count
  always_comb begin
    if (count[0]) begin
      med_sum = MED_W'(mid_hi) + MED_W'(mid_hi);
    end else begin
      med_sum = MED_W'(mid_lo) + MED_W'(mid_hi);
    end
  end

  // Chain commands
  always_comb begin
    ctl.ins   = s_acc && have_prev && !full;
    ctl.shift = (state == ST_DRAIN) && (step != half);
    ctl.clr   = (state == ST_EMIT) && out_free;
  end

  moi_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .ins_val  (ivl),
    .head_val (head_val)
  );

  // Run control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      prev_time <= '0;
      have_prev <= 1'b0;
      count     <= '0;
      dropped   <= 1'b0;
      step      <= '0;
    end else begin
      case (state)
        ST_RUN: begin
          if (s_acc) begin
            prev_time <= ts;
            have_prev <= 1'b1;
            if (have_prev && full) begin
              dropped <= 1'b1;
            end
            if (ctl.ins) begin
              count <= count + CNT_W'(1);
            end
            if (s_tlast) begin
              step <= '0;
              if (count == '0 && !ctl.ins) begin
                state <= ST_EMIT;
              end else begin
                state <= ST_DRAIN;
              end
            end
          end
        end
        ST_DRAIN: begin
          if (step == half) begin
            state <= ST_EMIT;
          end else begin
            step <= step + HALF_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            have_prev <= 1'b0;
            count     <= '0;
            dropped   <= 1'b0;
            state     <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // Capture the middle entries as they pass the head cell
  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) begin
      if (step == half - HALF_W'(1)) begin
        mid_lo <= head_val;
      end
      if (step == half) begin
        mid_hi <= head_val;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_med   <= (count == '0) ? '0 : med_sum;
      out_empty <= (count == '0);
      out_ovf   <= dropped;
    end
  end

  assign m_tdata = {{(moi_pkg::M_TDATA_W - MED_W){1'b0}}, out_med};
  assign m_tuser = {out_ovf, out_empty};

endmodule

/* hw/rtl/moi_cell.sv */
module moi_cell (
  input  logic          clk,
  input  logic          rst,
  input  moi_pkg::ctl_t ctl,
  input  moi_pkg::ivl_t ins_val,
  input  logic          take_in,
  input  moi_pkg::ivl_t left_val,
  input  logic          left_valid,
  input  moi_pkg::ivl_t right_val,
  input  logic          right_valid,
  output moi_pkg::ivl_t val,
  output logic          valid,
  output logic          le
);

  // Entry stays in place while it is not above the new interval
  assign le = valid && (val <= ins_val);

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.ins && !le) begin
      valid <= take_in ? 1'b1 : left_valid;
    end else if (ctl.shift) begin
      valid <= right_valid;
    end
  end

  // Stored interval: take the new one, move up from the left, or drain right
  always_ff @(posedge clk) begin
    if (ctl.ins && !le) begin
      val <= take_in ? ins_val : left_val;
    end else if (ctl.shift) begin
      val <= right_val;
    end
  end

endmodule

/* hw/rtl/moi_chain.sv */
module moi_chain (
  input  logic          clk,
  input  logic          rst,
  input  moi_pkg::ctl_t ctl,
  input  moi_pkg::ivl_t ins_val,
  output moi_pkg::ivl_t head_val
);

  localparam int N = moi_pkg::MAX_INTERVALS;

  moi_pkg::ivl_t vals   [N];
  logic          valids [N];
  logic          les    [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      moi_pkg::ivl_t lv;
      logic          lvd;
      logic          tk;
      moi_pkg::ivl_t rv;
      logic          rvd;

      // Left neighbor; the head cell takes the new interval when it moves
      if (i == 0) begin : g_head
        assign lv  = ins_val;
        assign lvd = 1'b0;
        assign tk  = 1'b1;
      end else begin : g_body
        assign lv  = vals[i-1];
        assign lvd = valids[i-1];
        assign tk  = les[i-1];
      end

      // Right neighbor; nothing beyond the tail cell
      if (i == N - 1) begin : g_tail
        assign rv  = ins_val;
        assign rvd = 1'b0;
      end else begin : g_mid
        assign rv  = vals[i+1];
        assign rvd = valids[i+1];
      end

      moi_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .ins_val     (ins_val),
        .take_in     (tk),
        .left_val    (lv),
        .left_valid  (lvd),
        .right_val   (rv),
        .right_valid (rvd),
        .val         (vals[i]),
        .valid       (valids[i]),
        .le          (les[i])
      );
    end
  endgenerate

  assign head_val = vals[0];

endmodule

/* tb/tb.sv */
module tb;

  localparam int RANDOM_ITEMS = 1700;
  localparam int QUIET_AFTER  = 1500;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 200;

  typedef logic [moi_pkg::TS_FIELD_W-1:0] stamp_t;

  typedef enum {
    RUN_RAMP,
    RUN_BACK,
    RUN_FLAT,
    RUN_SCATTER,
    RUN_EDGE
  } run_kind_e;

  typedef struct packed {
    moi_pkg::med_t median;
    logic          empty_run;
    logic          dropped;
  } median_result_t;

  // Predicts one median word per run and checks the block's words in order
  class interval_median_sb;
    logic [moi_pkg::TIME_BITS-1:0] prev_stamp;
    bit                            have_prev;
    moi_pkg::ivl_t                 sorted_ivls[$];
    bit                            dropped;
    median_result_t                expected_q[$];
    int                            errors;
    int                            runs;
    int                            empty_runs;
    int                            overflow_runs;
    int                            interval_total;
    int                            run_len;
    int                            longest_run;

    function new();
      prev_stamp     = '0;
      have_prev      = 1'b0;
      dropped        = 1'b0;
      errors         = 0;
      runs           = 0;
      empty_runs     = 0;
      overflow_runs  = 0;
      interval_total = 0;
      run_len        = 0;
      longest_run    = 0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    // Place the interval to the previous stamp, close the run on last
    function void note_timestamp(stamp_t ts, logic last);
      logic [moi_pkg::TIME_BITS-1:0] cur;
      moi_pkg::ivl_t                 ivl;
      int                            pos;
      int                            h;
      moi_pkg::med_t                 lo;
      moi_pkg::med_t                 hi;
      median_result_t                res;
      cur = ts[moi_pkg::TIME_BITS-1:0];
      run_len++;
      if (have_prev) begin
        ivl = $signed({1'b0, cur}) - $signed({1'b0, prev_stamp});
        interval_total++;
        if (sorted_ivls.size() >= moi_pkg::MAX_INTERVALS) begin
          dropped = 1'b1;
        end else begin
          pos = 0;
          while (pos < sorted_ivls.size() && sorted_ivls[pos] <= ivl) pos++;
          sorted_ivls.insert(pos, ivl);
        end
      end
      prev_stamp = cur;
      have_prev  = 1'b1;
      if (last) begin
        res = '0;
        if (sorted_ivls.size() == 0) begin
          res.empty_run = 1'b1;
          empty_runs++;
        end else begin
          h = sorted_ivls.size() / 2;
          if (sorted_ivls.size() % 2 == 1) begin
            lo = moi_pkg::med_t'(sorted_ivls[h]);
            hi = moi_pkg::med_t'(sorted_ivls[h]);
          end else begin
            lo = moi_pkg::med_t'(sorted_ivls[h-1]);
            hi = moi_pkg::med_t'(sorted_ivls[h]);
          end
          res.median = lo + hi;
        end
        res.dropped = dropped;
        if (dropped) overflow_runs++;
        expected_q.push_back(res);
        runs++;
        if (run_len > longest_run) longest_run = run_len;
        run_len   = 0;
        have_prev = 1'b0;
        dropped   = 1'b0;
        sorted_ivls.delete();
      end
    endfunction

    // Compare one result word with the oldest prediction
    task check_median(logic [moi_pkg::M_TDATA_W-1:0] data, logic [1:0] flags);
      median_result_t                 exp_res;
      logic [moi_pkg::M_TDATA_W-1:0]  exp_word;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word 0x%h with no run pending", data));
      end else begin
        exp_res  = expected_q.pop_front();
        exp_word = '0;
        exp_word[moi_pkg::MED_W-1:0] = exp_res.median;
        if (data[moi_pkg::MED_W-1:0] !== exp_res.median)
          report_mismatch($sformatf("median_x2 got %0d want %0d",
                                    $signed(data[moi_pkg::MED_W-1:0]), exp_res.median));
        if (data !== exp_word)
          report_mismatch($sformatf("tdata padding got 0x%h", data));
        if (flags[0] !== exp_res.empty_run)
          report_mismatch($sformatf("empty flag got %b want %b",
                                    flags[0], exp_res.empty_run));
        if (flags[1] !== exp_res.dropped)
          report_mismatch($sformatf("overflow flag got %b want %b",
                                    flags[1], exp_res.dropped));
      end
    endtask
  endclass

  logic                          clk;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [moi_pkg::S_TDATA_W-1:0] s_tdata  = '0;
  logic                          s_tlast  = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [moi_pkg::M_TDATA_W-1:0] m_tdata;
  logic [1:0]                    m_tuser;

  interval_median_sb sb = new();
  int  items_sent = 0;
  int  tx_pct     = 0;
  int  rx_pct     = 0;
  int  rx_hold    = 0;
  int  rx_cycles  = 0;
  bit  quiet      = 1'b0;

  median_of_intervals_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [47:0] timestamp
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [49:0] median_x2, rest zero
    .m_tuser  (m_tuser)    // [0] empty_res, [1] overflow
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up if the run hangs
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  // Watch both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_timestamp(s_tdata[moi_pkg::TS_FIELD_W-1:0], s_tlast);
      if (m_tvalid && m_tready) sb.check_median(m_tdata, m_tuser);
    end
  end

  // Stall the result side in random bursts, with a rate that changes over time
  always @(posedge clk) begin
    rx_cycles++;
    if (rx_cycles % 256 == 0) begin
      case ($urandom_range(0, 2))
        0: rx_pct = 0;
        1: rx_pct = 3;
        default: rx_pct = 15;
      endcase
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < rx_pct) begin
      rx_hold = $urandom_range(1, 19) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic stamp_t rand_stamp();
    return stamp_t'({$urandom(), $urandom()});
  endfunction

  function automatic stamp_t next_stamp(run_kind_e kind, stamp_t prev);
    if ($urandom_range(0, 9) == 0) return rand_stamp();
    case (kind)
      RUN_RAMP:    return prev + stamp_t'($urandom_range(0, 2000));
      RUN_BACK:    return prev - stamp_t'($urandom_range(0, 2000));
      RUN_FLAT:    return prev + stamp_t'($urandom_range(0, 3) == 0);
      RUN_SCATTER: return rand_stamp();
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return stamp_t'(1);
          default: return '1 - stamp_t'(1);
        endcase
      end
    endcase
  endfunction

  // Present one word and hold it until taken
  task send_word(stamp_t ts, logic last);
    s_tdata  <= moi_pkg::S_TDATA_W'(ts);
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Drop valid for a random burst now and then
  task tx_gap();
    if (!quiet && $urandom_range(0, 99) < tx_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task send_run(int n, run_kind_e kind);
    stamp_t ts;
    ts = rand_stamp();
    if ($urandom_range(0, 3) == 0) ts = '0;
    for (int i = 0; i < n; i++) begin
      if (i > 0) ts = next_stamp(kind, ts);
      tx_gap();
      send_word(ts, i == n - 1);
    end
  endtask

  // Hold off the sender until every predicted word has come out
  task wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int        run_idx;
    int        n;
    int        waited;
    run_kind_e kind;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty run
    send_word(48'd0, 1'b1);
    // Largest positive interval, then the most negative one
    send_word(48'd0, 1'b0);
    send_word('1, 1'b1);
    send_word('1, 1'b0);
    send_word(48'd0, 1'b1);
    // Odd count: 10, 20, 5 -> middle 10
    send_word(48'd100, 1'b0);
    send_word(48'd110, 1'b0);
    send_word(48'd130, 1'b0);
    send_word(48'd135, 1'b1);
    // Even count with going backwards: -100, 400, 1, -11
    send_word(48'd1000, 1'b0);
    send_word(48'd900, 1'b0);
    send_word(48'd1300, 1'b0);
    send_word(48'd1301, 1'b0);
    send_word(48'd1290, 1'b1);
    // Equal stamps give zero intervals
    send_word(48'd5, 1'b0);
    send_word(48'd5, 1'b0);
    send_word(48'd5, 1'b1);
    // Single stamp at the top of the range
    send_word('1, 1'b1);
    // Alternating bit patterns
    send_word(48'h5555_5555_5555, 1'b0);
    send_word(48'hAAAA_AAAA_AAAA, 1'b0);
    send_word(48'h5555_5555_5555, 1'b1);
    wait_results();

    // Random runs; a full store and one dropped interval are forced early
    run_idx = 0;
    while (items_sent < RANDOM_ITEMS + 21) begin
      case ($urandom_range(0, 4))
        0: kind = RUN_RAMP;
        1: kind = RUN_BACK;
        2: kind = RUN_FLAT;
        3: kind = RUN_SCATTER;
        default: kind = RUN_EDGE;
      endcase
      case ($urandom_range(0, 3))
        0, 1: tx_pct = 0;
        2: tx_pct = 5;
        default: tx_pct = 25;
      endcase
      if (run_idx == 5) n = moi_pkg::MAX_INTERVALS + 1;
      else if (run_idx == 12) n = moi_pkg::MAX_INTERVALS + 2;
      else if ($urandom_range(0, 99) == 0)
        n = $urandom_range(moi_pkg::MAX_INTERVALS - 6, moi_pkg::MAX_INTERVALS + 40);
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 2);
      else n = $urandom_range(3, 20);
      send_run(n, kind);
      run_idx++;
      if (run_idx == 40) wait_results();
      if (items_sent >= QUIET_AFTER) quiet = 1'b1;
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then let the block settle
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d median words never arrived", sb.pending()));

    $display("covered %0d runs (%0d empty, %0d with dropped intervals), %0d intervals,",
             sb.runs, sb.empty_runs, sb.overflow_runs, sb.interval_total);
    $display("longest run %0d stamps, %0d mismatches", sb.longest_run, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
